FILE: rtl/core/rbi_pkg.sv
// Shared types and constants for the ray/box intersection block.
package rbi_pkg;

  localparam int CoordWidth  = 16;
  localparam int TFracBits   = 16;
  localparam int TWidth      = TFracBits + 1;
  localparam int CfgIdxWidth = 3;
  localparam int NumAxes     = 3;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic [TWidth-1:0]            tval_t;

  typedef enum logic [1:0] {
    StatusMiss   = 2'd0,
    StatusInside = 2'd1,
    StatusHit    = 2'd2
  } status_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgMinX = 3'd0,
    CfgMinY = 3'd1,
    CfgMinZ = 3'd2,
    CfgMaxX = 3'd3,
    CfgMaxY = 3'd4,
    CfgMaxZ = 3'd5
  } cfg_idx_e;

  localparam coord_t BoxMinReset = coord_t'(4991);
  localparam coord_t BoxMaxReset = coord_t'(-4991);

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t delta_x;
    coord_t delta_y;
    coord_t delta_z;
  } ray_t;

  typedef struct packed {
    status_e hit_status;
    tval_t   hit_distance;
  } result_t;

  // What one axis lane hands to the merge stage.
  typedef struct packed {
    logic   miss;
    logic   face;
    coord_t o;
    coord_t d;
    tval_t  t;
  } lane_out_t;

endpackage

FILE: rtl/core/rbi_lane.sv
// One axis lane: slab classification followed by a pipelined restoring divider.
module rbi_lane (
  input  logic               clk_i,
  input  logic               adv_i,
  input  rbi_pkg::coord_t    origin_i,
  input  rbi_pkg::coord_t    delta_i,
  input  rbi_pkg::coord_t    lo_i,
  input  rbi_pkg::coord_t    hi_i,
  output rbi_pkg::lane_out_t lane_o
);

  localparam int W      = rbi_pkg::CoordWidth;
  localparam int TW     = rbi_pkg::TWidth;
  localparam int NStage = TW + 1;

  logic signed [W:0] o_ext, d_ext, num_lo, num_hi, neg_hi, neg_d;
  logic              below, above, miss_c;
  logic [W-1:0]      mag_c, dv_c;

  assign o_ext  = {origin_i[W-1], origin_i};
  assign d_ext  = {delta_i[W-1], delta_i};
  assign num_lo = {lo_i[W-1], lo_i} - o_ext;
  assign num_hi = {hi_i[W-1], hi_i} - o_ext;
  assign neg_hi = -num_hi;
  assign neg_d  = -d_ext;
  assign below  = origin_i < lo_i;
  assign above  = origin_i > hi_i;

  always_comb begin
    miss_c = 1'b0;
    mag_c  = '0;
    dv_c   = '0;
    if (below) begin
      miss_c = num_lo > d_ext;
      mag_c  = num_lo[W-1:0];
      dv_c   = d_ext[W-1:0];
    end else if (above) begin
      miss_c = num_hi < d_ext;
      mag_c  = neg_hi[W-1:0];
      dv_c   = neg_d[W-1:0];
    end
  end

  logic [W:0]             rem_q  [NStage];
  logic [W-1:0]           dv_q   [NStage];
  logic [TW-1:0]          quo_q  [NStage];
  rbi_pkg::coord_t        o_q    [NStage];
  rbi_pkg::coord_t        d_q    [NStage];
  logic                   miss_q [NStage];
  logic                   face_q [NStage];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q[0]  <= {1'b0, mag_c};
      dv_q[0]   <= dv_c;
      quo_q[0]  <= '0;
      o_q[0]    <= origin_i;
      d_q[0]    <= delta_i;
      miss_q[0] <= miss_c;
      face_q[0] <= below | above;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 1; s < NStage; s++) begin : g_div
    logic         bit_c;
    logic [W:0]   diff_c;
    logic [W:0]   rem_d;
    assign bit_c  = rem_q[s-1] >= {1'b0, dv_q[s-1]};
    assign diff_c = bit_c ? (rem_q[s-1] - {1'b0, dv_q[s-1]}) : rem_q[s-1];
    assign rem_d  = {diff_c[W-1:0], 1'b0};

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s]  <= rem_d;
        dv_q[s]   <= dv_q[s-1];
        quo_q[s]  <= {quo_q[s-1][TW-2:0], bit_c};
        o_q[s]    <= o_q[s-1];
        d_q[s]    <= d_q[s-1];
        miss_q[s] <= miss_q[s-1];
        face_q[s] <= face_q[s-1];
      end
    end
  end

  assign lane_o.miss = miss_q[NStage-1];
  assign lane_o.face = face_q[NStage-1];
  assign lane_o.o    = o_q[NStage-1];
  assign lane_o.d    = d_q[NStage-1];
  assign lane_o.t    = quo_q[NStage-1];

endmodule

FILE: rtl/core/rbi_merge.sv
// Merge stage: pick the entry plane, scale the deltas, run the plane tests.
module rbi_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  rbi_pkg::lane_out_t lane_i [rbi_pkg::NumAxes],
  input  rbi_pkg::coord_t    lo_i   [rbi_pkg::NumAxes],
  input  rbi_pkg::coord_t    hi_i   [rbi_pkg::NumAxes],
  output logic               valid_o,
  output rbi_pkg::result_t   res_o
);

  localparam int W  = rbi_pkg::CoordWidth;
  localparam int F  = rbi_pkg::TFracBits;
  localparam int TW = rbi_pkg::TWidth;
  localparam int N  = rbi_pkg::NumAxes;
  localparam int PW = W + TW + 1;
  localparam int SW = PW + 2;

  // Stage A: plane choice and products.
  logic [1:0]       pick_c;
  rbi_pkg::tval_t   best_c;
  logic             best_face_c, miss_c, inside_c;

  always_comb begin
    pick_c      = 2'd0;
    best_c      = lane_i[0].t;
    best_face_c = lane_i[0].face;
    miss_c      = 1'b0;
    inside_c    = 1'b1;
    for (int a = 0; a < N; a++) begin
      miss_c   = miss_c | lane_i[a].miss;
      inside_c = inside_c & ~lane_i[a].face;
    end
    for (int a = 1; a < N; a++) begin
      if (lane_i[a].face && (!best_face_c || lane_i[a].t > best_c)) begin
        pick_c      = 2'(a);
        best_c      = lane_i[a].t;
        best_face_c = 1'b1;
      end
    end
  end

  logic signed [PW-1:0] prod_q [N];
  rbi_pkg::coord_t      o_a_q  [N];
  logic [1:0]           pick_q;
  rbi_pkg::tval_t       best_q;
  logic                 miss_q, inside_q, va_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int a = 0; a < N; a++) begin
        prod_q[a] <= PW'(lane_i[a].d * $signed({1'b0, best_c}));
        o_a_q[a]  <= lane_i[a].o;
      end
      pick_q   <= pick_c;
      best_q   <= best_c;
      miss_q   <= miss_c;
      inside_q <= inside_c;
    end
  end

  // Stage B: hit point against the slabs of the other two axes.
  logic             out_c;
  rbi_pkg::result_t res_d;

  always_comb begin
    logic signed [SW-1:0] rel_lo, rel_hi, p_lo, p_hi;
    out_c = 1'b0;
    for (int a = 0; a < N; a++) begin
      rel_lo = SW'($signed({o_a_q[a][W-1], o_a_q[a]}) - $signed({lo_i[a][W-1], lo_i[a]}));
      rel_hi = SW'($signed({o_a_q[a][W-1], o_a_q[a]}) - $signed({hi_i[a][W-1], hi_i[a]}));
      p_lo   = (rel_lo <<< F) + SW'(prod_q[a]);
      p_hi   = (rel_hi <<< F) + SW'(prod_q[a]);
      if (pick_q != 2'(a) && (p_lo < 0 || p_hi > 0)) begin
        out_c = 1'b1;
      end
    end
    res_d.hit_status   = rbi_pkg::StatusMiss;
    res_d.hit_distance = '0;
    if (miss_q) begin
      res_d.hit_status = rbi_pkg::StatusMiss;
    end else if (inside_q) begin
      res_d.hit_status = rbi_pkg::StatusInside;
    end else if (!out_c) begin
      res_d.hit_status   = rbi_pkg::StatusHit;
      res_d.hit_distance = best_q;
    end
  end

  rbi_pkg::result_t res_q;
  logic             vb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = vb_q;
  assign res_o   = res_q;

endmodule

FILE: rtl/core/ray_box_intersect.sv
// Ray query against an axis-aligned box: one ray beat in, one result beat out.
// Each cycle takes one ray (origin and delta) unless the output is stalled;
// the result passes through classification, the per-axis restoring divider,
// which resolves one quotient bit per pipeline stage, the product stage and
// the plane-test stage; the hit distance is given in Q1.16. Three
// axis lanes run in parallel and a merge stage picks the entry plane. The
// whole pipeline holds while a finished result is stalled at the output.
// Box bounds come from six registers (min x/y/z at 0..2, max x/y/z at 3..5);
// write them only while no query is in flight.
module ray_box_intersect (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rbi_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [rbi_pkg::CoordWidth-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  rbi_pkg::ray_t                        in_ray_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output rbi_pkg::result_t                     out_res_o
);

  localparam int N      = rbi_pkg::NumAxes;
  localparam int NStage = rbi_pkg::TWidth + 1;

  rbi_pkg::coord_t box_lo_q [N];
  rbi_pkg::coord_t box_hi_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < N; a++) begin
        box_lo_q[a] <= rbi_pkg::BoxMinReset;
        box_hi_q[a] <= rbi_pkg::BoxMaxReset;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == rbi_pkg::CfgMinX) box_lo_q[0] <= cfg_data_i;
      if (cfg_idx_i == rbi_pkg::CfgMinY) box_lo_q[1] <= cfg_data_i;
      if (cfg_idx_i == rbi_pkg::CfgMinZ) box_lo_q[2] <= cfg_data_i;
      if (cfg_idx_i == rbi_pkg::CfgMaxX) box_hi_q[0] <= cfg_data_i;
      if (cfg_idx_i == rbi_pkg::CfgMaxY) box_hi_q[1] <= cfg_data_i;
      if (cfg_idx_i == rbi_pkg::CfgMaxZ) box_hi_q[2] <= cfg_data_i;
    end
  end

  // Advance everything unless the output beat is held.
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  logic vld_q [NStage];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NStage; s++) vld_q[s] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int s = 1; s < NStage; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  rbi_pkg::coord_t    org [N];
  rbi_pkg::coord_t    dlt [N];
  rbi_pkg::lane_out_t lane [N];

  assign org[0] = in_ray_i.origin_x;
  assign org[1] = in_ray_i.origin_y;
  assign org[2] = in_ray_i.origin_z;
  assign dlt[0] = in_ray_i.delta_x;
  assign dlt[1] = in_ray_i.delta_y;
  assign dlt[2] = in_ray_i.delta_z;

  for (genvar a = 0; a < N; a++) begin : g_lane
    rbi_lane u_lane (
      .clk_i    (clk_i),
      .adv_i    (adv),
      .origin_i (org[a]),
      .delta_i  (dlt[a]),
      .lo_i     (box_lo_q[a]),
      .hi_i     (box_hi_q[a]),
      .lane_o   (lane[a])
    );
  end

  rbi_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (vld_q[NStage-1]),
    .lane_i  (lane),
    .lo_i    (box_lo_q),
    .hi_i    (box_hi_q),
    .valid_o (out_valid_o),
    .res_o   (out_res_o)
  );

`ifndef ASSERT_OFF
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_res_o.hit_status == rbi_pkg::StatusMiss ||
                     out_res_o.hit_status == rbi_pkg::StatusInside ||
                     out_res_o.hit_status == rbi_pkg::StatusHit))
    else $error("illegal hit status");

  a_dist_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.hit_status != rbi_pkg::StatusHit)
      |-> out_res_o.hit_distance == '0)
    else $error("distance set without a hit");

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.hit_distance[rbi_pkg::TFracBits])
      |-> out_res_o.hit_distance[rbi_pkg::TFracBits-1:0] == '0)
    else $error("distance above one");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q[NStage-1]))
    else $error("pipeline moved while stalled");
`endif

endmodule

FILE: test/ray_box_intersect_tb.sv
// Testbench for the ray/box intersection block: directed table plus random rays.
`timescale 1ns / 1ps

module ray_box_intersect_tb;

  localparam int LatencyCycles = rbi_pkg::TFracBits + 4;
  localparam int RandomRays    = 1100;
  localparam longint CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [rbi_pkg::CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [rbi_pkg::CoordWidth-1:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  rbi_pkg::ray_t    in_ray_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  rbi_pkg::result_t out_res_o;

  ray_box_intersect uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .in_ray_i(in_ray_i), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_res_o(out_res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor copy of the box bounds; config index 0..2 is min, 3..5 is max.
  rbi_pkg::coord_t  box_lo [rbi_pkg::NumAxes];
  rbi_pkg::coord_t  box_hi [rbi_pkg::NumAxes];
  rbi_pkg::result_t pending_results [$];
  int      fail_count = 0;
  longint  cycle_count = 0;
  int      stall_mode = 0;

  function automatic rbi_pkg::result_t intersect_ray(rbi_pkg::ray_t r);
    rbi_pkg::result_t res;
    longint o [rbi_pkg::NumAxes];
    longint d [rbi_pkg::NumAxes];
    longint t [rbi_pkg::NumAxes];
    longint lo, hi, num, best, p;
    longint one;
    int pick;
    bit in_box;
    one = longint'(1) << rbi_pkg::TFracBits;
    res.hit_status = rbi_pkg::StatusMiss;
    res.hit_distance = '0;
    in_box = 1'b1;
    o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
    d[0] = r.delta_x;  d[1] = r.delta_y;  d[2] = r.delta_z;
    for (int a = 0; a < rbi_pkg::NumAxes; a++) begin
      lo = box_lo[a];
      hi = box_hi[a];
      t[a] = -1;
      if (o[a] < lo) begin
        num = lo - o[a];
        if (num > d[a]) return res;
        t[a] = (num << rbi_pkg::TFracBits) / d[a];
        in_box = 1'b0;
      end else if (o[a] > hi) begin
        num = hi - o[a];
        if (num < d[a]) return res;
        t[a] = ((-num) << rbi_pkg::TFracBits) / (-d[a]);
        in_box = 1'b0;
      end
    end
    if (in_box) begin
      res.hit_status = rbi_pkg::StatusInside;
      return res;
    end
    pick = 0;
    best = t[0];
    for (int a = 1; a < rbi_pkg::NumAxes; a++) begin
      if (t[a] > best) begin
        best = t[a];
        pick = a;
      end
    end
    for (int a = 0; a < rbi_pkg::NumAxes; a++) begin
      if (a != pick) begin
        p = o[a] * one + d[a] * best;
        if (p < longint'(box_lo[a]) * one || p > longint'(box_hi[a]) * one) return res;
      end
    end
    res.hit_status = rbi_pkg::StatusHit;
    res.hit_distance = rbi_pkg::tval_t'(best);
    return res;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[ray_box_intersect] ERROR");
      $finish;
    end
  end

  // Compare each delivered beat with the oldest prediction.
  always @(posedge clk_i) begin
    rbi_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat status=%0d t=%0d",
               out_res_o.hit_status, out_res_o.hit_distance);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_res_o.hit_status !== want.hit_status) begin
          $error("hit_status expected %0d actual %0d", want.hit_status,
                 out_res_o.hit_status);
          fail_count++;
        end
        if (out_res_o.hit_distance !== want.hit_distance) begin
          $error("hit_distance expected %0d actual %0d", want.hit_distance,
                 out_res_o.hit_distance);
          fail_count++;
        end
      end
    end
  end

  // Receiver stall pattern: modes of none, light, heavy, periodic.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 7) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= (cycle_count[2:0] < 3);
    endcase
  end

  task automatic write_box(rbi_pkg::cfg_idx_e idx, rbi_pkg::coord_t val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx < rbi_pkg::CfgMaxX) box_lo[idx] = val;
    else box_hi[idx - rbi_pkg::CfgMaxX] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_box(rbi_pkg::coord_t x0, rbi_pkg::coord_t y0, rbi_pkg::coord_t z0,
                         rbi_pkg::coord_t x1, rbi_pkg::coord_t y1, rbi_pkg::coord_t z1);
    write_box(rbi_pkg::CfgMinX, x0);
    write_box(rbi_pkg::CfgMinY, y0);
    write_box(rbi_pkg::CfgMinZ, z0);
    write_box(rbi_pkg::CfgMaxX, x1);
    write_box(rbi_pkg::CfgMaxY, y1);
    write_box(rbi_pkg::CfgMaxZ, z1);
  endtask

  // Present one ray at the falling edge and hold it until accepted.
  task automatic send_ray(rbi_pkg::ray_t r, bit typed, rbi_pkg::result_t typed_res);
    in_valid_i <= 1'b1;
    in_ray_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(typed ? typed_res : intersect_ray(r));
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (LatencyCycles + 4) @(negedge clk_i);
  endtask

  function automatic rbi_pkg::coord_t rand_coord(rbi_pkg::coord_t lo_b,
                                                 rbi_pkg::coord_t hi_b);
    int span;
    case ($urandom_range(0, 5))
      0: return rbi_pkg::coord_t'($urandom);
      1: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
      default: begin
        span = int'(hi_b) - int'(lo_b);
        return rbi_pkg::coord_t'(int'(lo_b) - 64 +
                                 $urandom_range(0, (span < 0 ? 0 : span) + 128));
      end
    endcase
  endfunction

  // Aim a ray from a random origin toward a point near the box.
  function automatic rbi_pkg::ray_t aimed_ray();
    rbi_pkg::ray_t r;
    rbi_pkg::coord_t tx, ty, tz;
    tx = rand_coord(box_lo[0], box_hi[0]);
    ty = rand_coord(box_lo[1], box_hi[1]);
    tz = rand_coord(box_lo[2], box_hi[2]);
    r.origin_x = rbi_pkg::coord_t'($urandom_range(0, 1) ? tx - $urandom_range(0, 8000)
                                                        : tx + $urandom_range(0, 8000));
    r.origin_y = rbi_pkg::coord_t'(ty + int'($urandom_range(0, 8000)) - 4000);
    r.origin_z = rbi_pkg::coord_t'(tz + int'($urandom_range(0, 8000)) - 4000);
    r.delta_x = rbi_pkg::coord_t'((int'(tx) - int'(r.origin_x)) * 2);
    r.delta_y = rbi_pkg::coord_t'((int'(ty) - int'(r.origin_y)) * 2);
    r.delta_z = rbi_pkg::coord_t'((int'(tz) - int'(r.origin_z)) * 2);
    return r;
  endfunction

  typedef struct {
    rbi_pkg::ray_t    ray;
    bit               typed;
    rbi_pkg::result_t res;
  } ray_row_t;

  initial begin
    ray_row_t rows [$];
    rbi_pkg::ray_t     r;
    rbi_pkg::result_t  miss_res, inside_res, none;
    int       burst;
    miss_res = '{rbi_pkg::StatusMiss, '0};
    inside_res = '{rbi_pkg::StatusInside, '0};
    none = miss_res;
    for (int a = 0; a < rbi_pkg::NumAxes; a++) begin
      box_lo[a] = rbi_pkg::BoxMinReset;
      box_hi[a] = rbi_pkg::BoxMaxReset;
    end
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset box is inverted: zero delta at the origin misses.
    send_ray('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, miss_res);
    send_ray('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 0, none);
    send_ray('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000}, 0, none);
    in_valid_i <= 1'b0;
    drain();

    set_box(-100, -100, -100, 100, 100, 100);
    rows = '{
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd5, 16'sd5, 16'sd5}, 1, inside_res},
      '{'{16'sd100, -16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, inside_res},
      '{'{-16'sd200, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, miss_res},
      '{'{-16'sd200, 16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd0}, 1,
        '{rbi_pkg::StatusHit, rbi_pkg::tval_t'(1 << rbi_pkg::TFracBits)}},
      '{'{-16'sd200, 16'sd0, 16'sd0, 16'sd99, 16'sd0, 16'sd0}, 1, miss_res},
      '{'{-16'sd200, 16'sd0, 16'sd0, 16'sd200, 16'sd0, 16'sd0}, 1,
        '{rbi_pkg::StatusHit, rbi_pkg::tval_t'(1 << (rbi_pkg::TFracBits - 1))}},
      '{'{16'sd200, 16'sd0, 16'sd0, -16'sd300, 16'sd7, 16'sd9}, 0, none},
      '{'{-16'sd101, -16'sd101, 16'sd0, 16'sd3, 16'sd3, 16'sd0}, 0, none},
      '{'{-16'sd200, -16'sd300, 16'sd0, 16'sd400, 16'sd400, 16'sd0}, 0, none},
      '{'{-16'sd200, 16'sd0, 16'sd300, 16'sd300, 16'sd50, -16'sd600}, 0, none},
      '{'{-16'sd101, 16'sd0, 16'sd0, 16'sd3, 16'sd400, 16'sd0}, 0, none},
      '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 0, none},
      '{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000}, 0, none},
      '{'{16'sh7fff, 16'sd0, 16'sd0, 16'sh8000, 16'sd1, -16'sd1}, 0, none}
    };
    foreach (rows[i]) send_ray(rows[i].ray, rows[i].typed, rows[i].res);
    in_valid_i <= 1'b0;
    drain();

    // Full-range box.
    set_box(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_ray('{16'sh8000, 16'sh7fff, 16'sd0, 16'sh7fff, 16'sh8000, 16'sd0}, 1, inside_res);
    in_valid_i <= 1'b0;
    drain();

    // Random phases; each phase after the first sets a fresh box, the last a point box at the origin.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) set_box(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      else if (ph > 0) begin
        for (int a = 0; a < rbi_pkg::NumAxes; a++) begin
          box_lo[a] = rbi_pkg::coord_t'($urandom_range(0, 40000) - 20000);
          box_hi[a] = ($urandom_range(0, 9) == 0) ? rbi_pkg::coord_t'($urandom)
                      : rbi_pkg::coord_t'(int'(box_lo[a]) + $urandom_range(0, 12000));
        end
        set_box(box_lo[0], box_lo[1], box_lo[2], box_hi[0], box_hi[1], box_hi[2]);
      end
      for (int n = 0; n < RandomRays / 8;) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst; b++, n++) begin
          if ($urandom_range(0, 3) == 0) r = rbi_pkg::ray_t'({$urandom, $urandom, $urandom});
          else r = aimed_ray();
          send_ray(r, 0, none);
        end
        if ($urandom_range(0, 2) != 0) begin
          in_valid_i <= 1'b0;
          in_ray_i <= rbi_pkg::ray_t'({$urandom, $urandom, $urandom});
          repeat ($urandom_range(1, 6)) @(negedge clk_i);
        end
      end
      in_valid_i <= 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("[ray_box_intersect] OK");
    end else begin
      $display("[ray_box_intersect] ERROR");
    end
    $finish;
  end

endmodule
